// File: design/cfe_pkg.sv
package cfe_pkg;

	localparam int DEF_MAX_WIDTH    = 32;
	localparam int DEF_MAX_HEIGHT   = 32;
	localparam int DEF_MAX_CHANNELS = 16;
	localparam int DEF_MAX_FILTERS  = 16;
	localparam int DEF_MAX_KERNEL   = 7;

	localparam int KIND_W     = 2;
	localparam int IDX_W      = 14;
	localparam int SAMPLE_W   = 16;
	localparam int FILT_W     = 4;
	localparam int OPOS_W     = 5;
	localparam int RESULT_W   = 32;

	localparam int STRIDE_W   = 3;
	localparam int PAD_W      = 2;
	localparam int KSIZE_W    = 3;
	localparam int FCNT_W     = 5;
	localparam int CCNT_W     = 5;
	localparam int IMG_W      = 6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// signed tap position in the padded frame, shifted by the border
	localparam int POS_W      = 10;

	localparam logic [KIND_W-1:0] KIND_WEIGHT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BIAS    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STRIDE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD           = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;

	localparam logic [STRIDE_W-1:0] RST_STRIDE        = 3'd1;
	localparam logic [PAD_W-1:0]    RST_PAD           = 2'd0;
	localparam logic [KSIZE_W-1:0]  RST_KERNEL_SIZE   = 3'd3;
	localparam logic [FCNT_W-1:0]   RST_FILTER_COUNT  = 5'd10;
	localparam logic [CCNT_W-1:0]   RST_CHANNEL_COUNT = 5'd3;
	localparam logic [IMG_W-1:0]    RST_IMAGE_WIDTH   = 6'd28;
	localparam logic [IMG_W-1:0]    RST_IMAGE_HEIGHT  = 6'd28;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SETUP,
		ST_BASE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

// File: design/cfe_req_if.sv
interface cfe_req_if;
	import cfe_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic [IDX_W-1:0]           store_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic [FILT_W-1:0]          filter_index;
	logic [OPOS_W-1:0]          out_row;
	logic [OPOS_W-1:0]          out_col;

	modport source (
		output valid, kind, store_index, sample_value, filter_index, out_row, out_col,
		input  ready
	);
	modport sink (
		input  valid, kind, store_index, sample_value, filter_index, out_row, out_col,
		output ready
	);
endinterface

// File: design/cfe_rsp_if.sv
interface cfe_rsp_if;
	import cfe_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [RESULT_W-1:0] result_value;
	logic                       error;

	modport source (
		output valid, result_value, error,
		input  ready
	);
	modport sink (
		input  valid, result_value, error,
		output ready
	);
endinterface

// File: design/cfe_cfg_if.sv
interface cfe_cfg_if;
	import cfe_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: design/cfe_ram.sv
module cfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/conv2d_forward_engine_unit.sv
// Forward 2-D convolution engine with stride and zero padding. A load request (weight, bias
// or pixel, signed Q8.8) is taken and writes its store; loads beyond a store's
// depth are dropped and give no response. A compute request names a filter and an output
// position and gives one response: the sum of weight times pixel over all channels and
// kernel taps plus the filter bias, signed Q16.16 saturated to 32 bits, or error with a zero
// value when the geometry or position is invalid. One multiply-accumulate unit with one read
// port per store does one tap per cycle, and the engine takes no request while a compute
// request, valid or invalid, is in progress. A finished response waits in the output
// register while the next request is taken. Stores are not cleared by reset: every entry a
// compute request reads must have been loaded first.
module conv2d_forward_engine_unit #(
	parameter int MAX_WIDTH    = cfe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = cfe_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = cfe_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_FILTERS  = cfe_pkg::DEF_MAX_FILTERS,
	parameter int MAX_KERNEL   = cfe_pkg::DEF_MAX_KERNEL
) (
	input  logic      clk,
	input  logic      arst_n,
	cfe_req_if.sink   req,
	cfe_rsp_if.source rsp,
	cfe_cfg_if.sink   cfg
);
	import cfe_pkg::*;

	localparam int PIX_DEPTH  = MAX_CHANNELS * MAX_WIDTH * MAX_HEIGHT;
	localparam int WGT_DEPTH  = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int BIAS_DEPTH = MAX_FILTERS;
	localparam int PIX_AW     = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
	localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
	localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
	localparam int MAX_TAPS   = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS + 1) + 1;
	localparam int KK_W       = 2 * KSIZE_W;
	localparam int CKK_W      = CCNT_W + KK_W;
	localparam int HW_W       = 2 * IMG_W;
	localparam int OFF_W      = ((PIX_AW > POS_W + IMG_W) ? PIX_AW : POS_W + IMG_W) + 2;
	localparam int PW_W       = IMG_W + 1;

	// config registers
	logic [STRIDE_W-1:0] stride_q;
	logic [PAD_W-1:0]    pad_q;
	logic [KSIZE_W-1:0]  ksize_q;
	logic [FCNT_W-1:0]   fcnt_q;
	logic [CCNT_W-1:0]   ccnt_q;
	logic [IMG_W-1:0]    img_w_q;
	logic [IMG_W-1:0]    img_h_q;

	state_t state_q, state_d;
	logic   req_fire, req_ready, out_load, rsp_fire;

	logic [FILT_W-1:0] f_q;
	logic [OPOS_W-1:0] orow_q, ocol_q;

	logic signed [POS_W-1:0] ir0_q, ic0_q, ir_q, ic_q;
	logic [KK_W-1:0]         kk_q;
	logic [HW_W-1:0]         hw_q;
	logic [CKK_W-1:0]        ckk_q;
	logic signed [OFF_W-1:0] row0_q, row_q, chan_q;
	logic [WGT_AW-1:0]       waddr_q;
	logic [CCNT_W-1:0]       l_q;
	logic [KSIZE_W-1:0]      r_q, c_q;

	logic                     tap_v_s1, inimg_s1, last_s1;
	logic                     v_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_s3;

	logic signed [RESULT_W-1:0] res_q;
	logic                       err_q;
	logic                       out_v_q;
	logic signed [RESULT_W-1:0] out_val_q;
	logic                       out_err_q;

	logic                       geo_bad, kbig, pos_bad, err_now;
	logic [PW_W-1:0]            pw, ph;
	logic [POS_W-1:0]           rspan, cspan;
	logic                       c_end, r_end, l_end, in_img;
	logic signed [OFF_W-1:0]    pix_full;
	logic signed [ACC_W-1:0]    sum_fin;
	logic signed [RESULT_W-1:0] sat_fin;

	logic                      pix_we, wgt_we, bias_we;
	logic [SAMPLE_W-1:0]       pix_rdata, wgt_rdata, bias_rdata;
	logic signed [SAMPLE_W-1:0] pix_m;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= RST_STRIDE;
			pad_q    <= RST_PAD;
			ksize_q  <= RST_KERNEL_SIZE;
			fcnt_q   <= RST_FILTER_COUNT;
			ccnt_q   <= RST_CHANNEL_COUNT;
			img_w_q  <= RST_IMAGE_WIDTH;
			img_h_q  <= RST_IMAGE_HEIGHT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STRIDE:        stride_q <= cfg.data[STRIDE_W-1:0];
				REG_PAD:           pad_q    <= cfg.data[PAD_W-1:0];
				REG_KERNEL_SIZE:   ksize_q  <= cfg.data[KSIZE_W-1:0];
				REG_FILTER_COUNT:  fcnt_q   <= cfg.data[FCNT_W-1:0];
				REG_CHANNEL_COUNT: ccnt_q   <= cfg.data[CCNT_W-1:0];
				REG_IMAGE_WIDTH:   img_w_q  <= cfg.data[IMG_W-1:0];
				REG_IMAGE_HEIGHT:  img_h_q  <= cfg.data[IMG_W-1:0];
				default: ;
			endcase
		end
	end

	// stores
	assign req_fire = req.valid && req_ready;
	assign wgt_we   = req_fire && (req.kind == KIND_WEIGHT) && (int'(req.store_index) < WGT_DEPTH);
	assign bias_we  = req_fire && (req.kind == KIND_BIAS) && (int'(req.store_index) < BIAS_DEPTH);
	assign pix_we   = req_fire && (req.kind == KIND_PIXEL) && (int'(req.store_index) < PIX_DEPTH);

	cfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (PIX_AW'(req.store_index)),
		.wdata (req.sample_value),
		.raddr (pix_full[PIX_AW-1:0]),
		.rdata (pix_rdata)
	);

	cfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(WGT_DEPTH)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (WGT_AW'(req.store_index)),
		.wdata (req.sample_value),
		.raddr (waddr_q),
		.rdata (wgt_rdata)
	);

	cfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(BIAS_DEPTH)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (BIAS_AW'(req.store_index)),
		.wdata (req.sample_value),
		.raddr (BIAS_AW'(f_q)),
		.rdata (bias_rdata)
	);

	// geometry and position checks
	always_comb begin
		geo_bad = (stride_q == '0) || (ksize_q == '0) || (int'(ksize_q) > MAX_KERNEL) ||
			(ccnt_q == '0) || (int'(ccnt_q) > MAX_CHANNELS) ||
			(fcnt_q == '0) || (int'(fcnt_q) > MAX_FILTERS) ||
			(img_w_q == '0) || (int'(img_w_q) > MAX_WIDTH) ||
			(img_h_q == '0) || (int'(img_h_q) > MAX_HEIGHT);
		pw      = PW_W'(img_w_q) + PW_W'({pad_q, 1'b0});
		ph      = PW_W'(img_h_q) + PW_W'({pad_q, 1'b0});
		kbig    = (PW_W'(ksize_q) > pw) || (PW_W'(ksize_q) > ph);
		rspan   = POS_W'(orow_q) * POS_W'(stride_q) + POS_W'(ksize_q);
		cspan   = POS_W'(ocol_q) * POS_W'(stride_q) + POS_W'(ksize_q);
		pos_bad = (FCNT_W'(f_q) >= fcnt_q) || (rspan > POS_W'(ph)) || (cspan > POS_W'(pw));
		err_now = geo_bad || kbig || pos_bad;
	end

	// tap walk
	always_comb begin
		c_end    = (c_q == ksize_q - KSIZE_W'(1));
		r_end    = (r_q == ksize_q - KSIZE_W'(1));
		l_end    = (l_q == ccnt_q - CCNT_W'(1));
		in_img   = !ir_q[POS_W-1] && (ir_q < $signed(POS_W'(img_h_q))) &&
			!ic_q[POS_W-1] && (ic_q < $signed(POS_W'(img_w_q)));
		pix_full = chan_q + row_q + OFF_W'(ic_q);
	end

	// bias and saturation
	always_comb begin
		sum_fin = acc_q + (ACC_W'($signed(bias_rdata)) <<< 8);
		if (!sum_fin[ACC_W-1] && (|sum_fin[ACC_W-2:RESULT_W-1])) begin
			sat_fin = {1'b0, {(RESULT_W-1){1'b1}}};
		end else if (sum_fin[ACC_W-1] && !(&sum_fin[ACC_W-2:RESULT_W-1])) begin
			sat_fin = {1'b1, {(RESULT_W-1){1'b0}}};
		end else begin
			sat_fin = sum_fin[RESULT_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid && (req.kind == KIND_COMPUTE)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = err_now ? ST_OUT : ST_SETUP;
			end
			ST_SETUP: state_d = ST_BASE;
			ST_BASE:  state_d = ST_RUN;
			ST_RUN: begin
				if (c_end && r_end && l_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (done_s3) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_v_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = req_ready;

	// request capture, setup and address walk
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					f_q    <= req.filter_index;
					orow_q <= req.out_row;
					ocol_q <= req.out_col;
				end
			end
			ST_CHECK: begin
				ir0_q <= $signed(POS_W'(orow_q) * POS_W'(stride_q)) - $signed(POS_W'(pad_q));
				ic0_q <= $signed(POS_W'(ocol_q) * POS_W'(stride_q)) - $signed(POS_W'(pad_q));
				kk_q  <= KK_W'(ksize_q) * KK_W'(ksize_q);
				hw_q  <= HW_W'(img_h_q) * HW_W'(img_w_q);
				res_q <= '0;
				err_q <= 1'b1;
			end
			ST_SETUP: begin
				row0_q <= OFF_W'(ir0_q) * OFF_W'($signed({1'b0, img_w_q}));
				ckk_q  <= CKK_W'(ccnt_q) * CKK_W'(kk_q);
				ir_q   <= ir0_q;
				ic_q   <= ic0_q;
				chan_q <= '0;
				l_q    <= '0;
				r_q    <= '0;
				c_q    <= '0;
			end
			ST_BASE: begin
				waddr_q <= WGT_AW'((CKK_W + FILT_W)'(f_q) * (CKK_W + FILT_W)'(ckk_q));
				row_q   <= row0_q;
			end
			ST_RUN: begin
				waddr_q <= waddr_q + WGT_AW'(1);
				if (c_end) begin
					c_q  <= '0;
					ic_q <= ic0_q;
					if (r_end) begin
						r_q   <= '0;
						ir_q  <= ir0_q;
						row_q <= row0_q;
						l_q   <= l_q + CCNT_W'(1);
						chan_q <= chan_q + OFF_W'($signed({1'b0, hw_q}));
					end else begin
						r_q   <= r_q + KSIZE_W'(1);
						ir_q  <= ir_q + POS_W'(1);
						row_q <= row_q + OFF_W'($signed({1'b0, img_w_q}));
					end
				end else begin
					c_q  <= c_q + KSIZE_W'(1);
					ic_q <= ic_q + POS_W'(1);
				end
			end
			ST_FIN: begin
				res_q <= sat_fin;
				err_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_v_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			tap_v_s1 <= (state_q == ST_RUN);
			last_s1  <= (state_q == ST_RUN) && c_end && r_end && l_end;
			v_s2     <= tap_v_s1;
			last_s2  <= tap_v_s1 && last_s1;
			done_s3  <= v_s2 && last_s2;
		end
	end

	assign pix_m = inimg_s1 ? $signed(pix_rdata) : '0;

	always_ff @(posedge clk) begin
		inimg_s1 <= in_img;
		prod_s2  <= pix_m * $signed(wgt_rdata);
		if (state_q == ST_SETUP) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// response register
	assign rsp_fire = out_v_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp_fire) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q <= res_q;
			out_err_q <= err_q;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.result_value = out_val_q;
	assign rsp.error        = out_err_q;
endmodule

// File: tb/sv/conv2d_forward_engine_unit_tb.sv
module conv2d_forward_engine_unit_tb;
	import cfe_pkg::*;

	localparam int PIX_DEPTH     = DEF_MAX_CHANNELS * DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int WGT_DEPTH     = DEF_MAX_FILTERS * DEF_MAX_CHANNELS * DEF_MAX_KERNEL * DEF_MAX_KERNEL;
	localparam int BIAS_DEPTH    = DEF_MAX_FILTERS;
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES    = 1000;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam longint SUM_MAX   = 64'sd2147483647;
	localparam longint SUM_MIN   = -64'sd2147483648;

	typedef struct {
		logic [KIND_W-1:0]          kind;
		logic [IDX_W-1:0]           idx;
		logic signed [SAMPLE_W-1:0] sample;
		logic [FILT_W-1:0]          filt;
		logic [OPOS_W-1:0]          row;
		logic [OPOS_W-1:0]          col;
	} conv_req_t;

	typedef struct {
		logic signed [RESULT_W-1:0] value;
		logic                       err;
	} conv_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	cfe_req_if req_bus ();
	cfe_rsp_if rsp_bus ();
	cfe_cfg_if cfg_bus ();

	conv2d_forward_engine_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// geometry as the block holds it
	logic [STRIDE_W-1:0] geo_stride;
	logic [PAD_W-1:0]    geo_pad;
	logic [KSIZE_W-1:0]  geo_ksize;
	logic [FCNT_W-1:0]   geo_fcount;
	logic [CCNT_W-1:0]   geo_ccount;
	logic [IMG_W-1:0]    geo_width;
	logic [IMG_W-1:0]    geo_height;

	// store contents for prediction
	logic signed [SAMPLE_W-1:0] pix_mem [PIX_DEPTH];
	logic signed [SAMPLE_W-1:0] wgt_mem [WGT_DEPTH];
	logic signed [SAMPLE_W-1:0] bias_mem [BIAS_DEPTH];

	// entries already loaded by queued requests
	bit pix_set [PIX_DEPTH];
	bit wgt_set [WGT_DEPTH];
	bit bias_set [BIAS_DEPTH];

	conv_req_t pending_reqs [$];
	conv_rsp_t expected_sums [$];
	conv_req_t held_req;

	int send_idle_pct;
	int recv_stall_pct;
	int phase_items;
	int phase_computes;
	int requests_done;
	int responses_checked;
	int error_results;
	int saturated_results;
	int geometry_count;
	int mismatch_count;
	int cycle_count;

	function automatic bit geometry_ok(output int out_w, output int out_h);
		int k, pw, ph;
		k = int'(geo_ksize);
		pw = int'(geo_width) + 2 * int'(geo_pad);
		ph = int'(geo_height) + 2 * int'(geo_pad);
		out_w = 0;
		out_h = 0;
		if (geo_stride == 0 || k == 0 || k > DEF_MAX_KERNEL ||
				geo_ccount == 0 || geo_ccount > DEF_MAX_CHANNELS ||
				geo_fcount == 0 || geo_fcount > DEF_MAX_FILTERS ||
				geo_width == 0 || geo_width > DEF_MAX_WIDTH ||
				geo_height == 0 || geo_height > DEF_MAX_HEIGHT)
			return 1'b0;
		if (k > pw || k > ph)
			return 1'b0;
		out_w = 1 + (pw - k) / int'(geo_stride);
		out_h = 1 + (ph - k) / int'(geo_stride);
		return 1'b1;
	endfunction

	function automatic void apply_request(conv_req_t q);
		int ow, oh, s, p, k, cn, w, h, f, l, r, c, pr, pc;
		longint acc;
		logic signed [SAMPLE_W-1:0] px;
		conv_rsp_t res;
		case (q.kind)
			KIND_WEIGHT: if (q.idx < WGT_DEPTH) wgt_mem[q.idx] = q.sample;
			KIND_BIAS: if (q.idx < BIAS_DEPTH) bias_mem[q.idx] = q.sample;
			KIND_PIXEL: if (q.idx < PIX_DEPTH) pix_mem[q.idx] = q.sample;
			default: begin
				res.value = '0;
				res.err = 1'b1;
				if (geometry_ok(ow, oh) && q.filt < geo_fcount && q.row < oh && q.col < ow) begin
					s = int'(geo_stride);
					p = int'(geo_pad);
					k = int'(geo_ksize);
					cn = int'(geo_ccount);
					w = int'(geo_width);
					h = int'(geo_height);
					f = int'(q.filt);
					acc = 0;
					for (l = 0; l < cn; l++)
						for (r = 0; r < k; r++)
							for (c = 0; c < k; c++) begin
								pr = int'(q.row) * s + r;
								pc = int'(q.col) * s + c;
								px = '0;
								if (pr >= p && pr < h + p && pc >= p && pc < w + p)
									px = pix_mem[(l * h + pr - p) * w + pc - p];
								acc += longint'(px) * longint'(wgt_mem[((f * cn + l) * k + r) * k + c]);
							end
					acc += longint'(bias_mem[f]) * 256;
					if (acc > SUM_MAX || acc < SUM_MIN) begin
						saturated_results++;
						acc = (acc > SUM_MAX) ? SUM_MAX : SUM_MIN;
					end
					res.value = acc[RESULT_W-1:0];
					res.err = 1'b0;
				end else begin
					error_results++;
				end
				expected_sums.push_back(res);
			end
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic conv_req_t rand_fields();
		conv_req_t q;
		q.kind = KIND_W'($urandom_range(0, 3));
		q.idx = IDX_W'($urandom);
		q.sample = rand_sample();
		q.filt = FILT_W'($urandom);
		q.row = OPOS_W'($urandom);
		q.col = OPOS_W'($urandom);
		return q;
	endfunction

	function automatic void queue_load(logic [KIND_W-1:0] kind, int idx,
			logic signed [SAMPLE_W-1:0] value);
		conv_req_t q;
		q = rand_fields();
		q.kind = kind;
		q.idx = IDX_W'(idx);
		q.sample = value;
		pending_reqs.push_back(q);
		// loads past a store's end are dropped and not counted
		case (kind)
			KIND_WEIGHT: if (idx < WGT_DEPTH) begin
				wgt_set[idx] = 1'b1;
				phase_items++;
			end
			KIND_BIAS: if (idx < BIAS_DEPTH) begin
				bias_set[idx] = 1'b1;
				phase_items++;
			end
			default: if (idx < PIX_DEPTH) begin
				pix_set[idx] = 1'b1;
				phase_items++;
			end
		endcase
	endfunction

	// loads whatever the position reads that was never loaded, then the compute
	function automatic void queue_compute(int f, int row, int col);
		conv_req_t q;
		int ow, oh, s, p, k, cn, w, h, l, r, c, pr, pc, wi, pi;
		if (geometry_ok(ow, oh) && f < geo_fcount && row < oh && col < ow) begin
			s = int'(geo_stride);
			p = int'(geo_pad);
			k = int'(geo_ksize);
			cn = int'(geo_ccount);
			w = int'(geo_width);
			h = int'(geo_height);
			for (l = 0; l < cn; l++)
				for (r = 0; r < k; r++)
					for (c = 0; c < k; c++) begin
						wi = ((f * cn + l) * k + r) * k + c;
						if (!wgt_set[wi])
							queue_load(KIND_WEIGHT, wi, rand_sample());
						pr = row * s + r;
						pc = col * s + c;
						if (pr >= p && pr < h + p && pc >= p && pc < w + p) begin
							pi = (l * h + pr - p) * w + pc - p;
							if (!pix_set[pi])
								queue_load(KIND_PIXEL, pi, rand_sample());
						end
					end
			if (!bias_set[f])
				queue_load(KIND_BIAS, f, rand_sample());
		end
		q = rand_fields();
		q.kind = KIND_COMPUTE;
		q.filt = FILT_W'(f);
		q.row = OPOS_W'(row);
		q.col = OPOS_W'(col);
		pending_reqs.push_back(q);
		phase_items++;
		phase_computes++;
	endfunction

	function automatic void queue_random_request();
		int ow, oh, lim_r, lim_c, sel, span;
		logic [KIND_W-1:0] kind;
		sel = $urandom_range(0, 99);
		kind = KIND_W'($urandom_range(0, 2));
		if (sel < 55 && geometry_ok(ow, oh)) begin
			// half the positions near the origin so loaded data gets reused
			if ($urandom_range(0, 1)) begin
				lim_r = (oh < 3) ? oh : 3;
				lim_c = (ow < 3) ? ow : 3;
			end else begin
				lim_r = (oh < 32) ? oh : 32;
				lim_c = (ow < 32) ? ow : 32;
			end
			queue_compute($urandom_range(0, geo_fcount - 1), $urandom_range(0, lim_r - 1),
				$urandom_range(0, lim_c - 1));
		end else if (sel < 65) begin
			queue_compute($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31));
		end else if (sel < 88) begin
			case (kind)
				KIND_WEIGHT: span = int'(geo_fcount) * geo_ksize * geo_ksize * geo_ccount;
				KIND_BIAS: span = int'(geo_fcount);
				default: span = int'(geo_ccount) * geo_width * geo_height;
			endcase
			if (span > WGT_DEPTH && kind == KIND_WEIGHT)
				span = WGT_DEPTH;
			if (span > BIAS_DEPTH && kind == KIND_BIAS)
				span = BIAS_DEPTH;
			if (span > PIX_DEPTH)
				span = PIX_DEPTH;
			if (span < 1)
				span = 1;
			queue_load(kind, $urandom_range(0, span - 1), rand_sample());
		end else begin
			queue_load(kind, $urandom_range(0, 16383), rand_sample());
		end
	endfunction

	task automatic wait_quiet();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || req_bus.valid || expected_sums.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= CFG_DATA_W'(value);
		do @(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_STRIDE: geo_stride = STRIDE_W'(value);
			REG_PAD: geo_pad = PAD_W'(value);
			REG_KERNEL_SIZE: geo_ksize = KSIZE_W'(value);
			REG_FILTER_COUNT: geo_fcount = FCNT_W'(value);
			REG_CHANNEL_COUNT: geo_ccount = CCNT_W'(value);
			REG_IMAGE_WIDTH: geo_width = IMG_W'(value);
			REG_IMAGE_HEIGHT: geo_height = IMG_W'(value);
			default: ;
		endcase
	endtask

	task automatic set_geometry(int s, int p, int k, int f, int c, int w, int h);
		write_reg(REG_STRIDE, s);
		write_reg(REG_PAD, p);
		write_reg(REG_KERNEL_SIZE, k);
		write_reg(REG_FILTER_COUNT, f);
		write_reg(REG_CHANNEL_COUNT, c);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		geometry_count++;
	endtask

	task automatic bad_geometry_phase(int s, int p, int k, int f, int c, int w, int h);
		set_geometry(s, p, k, f, c, w, h);
		queue_compute(0, 0, 0);
		queue_compute($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31));
		wait_quiet();
	endtask

	task automatic random_phase(int s, int p, int k, int f, int c, int w, int h, int budget);
		set_geometry(s, p, k, f, c, w, h);
		phase_items = 0;
		phase_computes = 0;
		while (phase_items < budget || phase_computes < 10)
			queue_random_request();
		wait_quiet();
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				apply_request(held_req);
				requests_done++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					held_req = pending_reqs.pop_front();
					req_bus.valid <= 1'b1;
					req_bus.kind <= held_req.kind;
					req_bus.store_index <= held_req.idx;
					req_bus.sample_value <= held_req.sample;
					req_bus.filter_index <= held_req.filt;
					req_bus.out_row <= held_req.row;
					req_bus.out_col <= held_req.col;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_sums.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected response: value %0d error %0b",
							rsp_bus.result_value, rsp_bus.error);
				end else begin
					conv_rsp_t want;
					want = expected_sums.pop_front();
					if (rsp_bus.result_value !== want.value || rsp_bus.error !== want.err) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("response %0d: expected value %0d error %0b, got value %0d error %0b",
								responses_checked, want.value, want.err,
								rsp_bus.result_value, rsp_bus.error);
					end
					responses_checked++;
				end
			end
			rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("no progress after %0d cycles", CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.kind = KIND_WEIGHT;
		req_bus.store_index = '0;
		req_bus.sample_value = '0;
		req_bus.filter_index = '0;
		req_bus.out_row = '0;
		req_bus.out_col = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_STRIDE;
		cfg_bus.data = '0;
		geo_stride = RST_STRIDE;
		geo_pad = RST_PAD;
		geo_ksize = RST_KERNEL_SIZE;
		geo_fcount = RST_FILTER_COUNT;
		geo_ccount = RST_CHANNEL_COUNT;
		geo_width = RST_IMAGE_WIDTH;
		geo_height = RST_IMAGE_HEIGHT;
		send_idle_pct = 10;
		recv_stall_pct = 62;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// 2x2 image, 2x2 kernel, one output position
		set_geometry(1, 0, 2, 2, 1, 2, 2);
		for (i = 0; i < 4; i++)
			queue_load(KIND_WEIGHT, i, 16'sh8000);
		for (i = 0; i < 4; i++)
			queue_load(KIND_PIXEL, i, 16'sh8000);
		queue_load(KIND_BIAS, 0, 16'sh7fff);
		queue_compute(0, 0, 0);
		for (i = 0; i < 4; i++)
			queue_load(KIND_PIXEL, i, 16'sh7fff);
		queue_compute(0, 0, 0);
		queue_load(KIND_WEIGHT, 4, 16'sh0100);
		queue_load(KIND_WEIGHT, 5, 16'shff00);
		queue_load(KIND_WEIGHT, 6, 16'sh0001);
		queue_load(KIND_WEIGHT, 7, 16'sh7fff);
		queue_load(KIND_BIAS, 1, 16'sh8000);
		queue_compute(1, 0, 0);
		queue_compute(15, 31, 31);
		queue_compute(2, 0, 0);
		queue_compute(0, 1, 0);
		queue_load(KIND_WEIGHT, WGT_DEPTH, 16'sh1234);
		queue_load(KIND_BIAS, 16383, 16'sh4321);
		queue_load(KIND_PIXEL, PIX_DEPTH - 1, 16'sh5555);
		queue_load(KIND_WEIGHT, WGT_DEPTH - 1, 16'shaaaa);
		queue_load(KIND_BIAS, BIAS_DEPTH - 1, 16'sh00ff);
		wait_quiet();

		// geometries the block must refuse
		bad_geometry_phase(0, 0, 3, 10, 3, 28, 28);
		bad_geometry_phase(1, 0, 0, 10, 3, 28, 28);
		bad_geometry_phase(1, 0, 3, 10, 0, 28, 28);
		bad_geometry_phase(1, 0, 3, 10, 17, 28, 28);
		bad_geometry_phase(1, 0, 3, 0, 3, 28, 28);
		bad_geometry_phase(1, 0, 3, 17, 3, 28, 28);
		bad_geometry_phase(1, 0, 3, 10, 3, 0, 28);
		bad_geometry_phase(1, 0, 3, 10, 3, 33, 28);
		bad_geometry_phase(1, 0, 3, 10, 3, 28, 0);
		bad_geometry_phase(1, 0, 3, 10, 3, 28, 33);
		bad_geometry_phase(1, 1, 7, 10, 3, 3, 28);
		bad_geometry_phase(1, 1, 7, 10, 3, 28, 3);

		random_phase(1, 0, 1, 1, 1, 1, 1, 145);
		random_phase(2, 1, 3, 4, 2, 9, 7, 145);
		random_phase(7, 3, 7, 2, 1, 12, 12, 145);
		random_phase(4, 3, 7, 2, 1, 1, 1, 145);
		send_idle_pct = 62;
		recv_stall_pct = 10;
		random_phase(1, 0, 1, 16, 16, 32, 32, 145);
		random_phase(3, 2, 5, 3, 3, 12, 10, 145);
		random_phase(1, 0, 3, 2, 2, 3, 3, 145);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(5, 2, 4, 8, 4, 20, 24, 145);
		random_phase(1, 1, 3, 10, 3, 28, 28, 145);
		random_phase(1, 0, 3, 10, 3, 28, 28, 145);

		repeat (END_CYCLES) @(posedge clk);
		if (expected_sums.size() != 0) begin
			$display("%0d responses never arrived", expected_sums.size());
			mismatch_count += expected_sums.size();
		end
		$display("%0d requests over %0d register settings, %0d responses checked",
			requests_done, geometry_count, responses_checked);
		$display("%0d error responses, %0d saturated sums, %0d mismatches",
			error_results, saturated_results, mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
